/* rtl/sss_pkg.sv */
// shared types and constants for the string separator splitter
// used by sss_fifo and string_separator_splitter; no dependencies
package sss_pkg;

  // width of every result field
  localparam int PIECE_W = 16;
  // result queue depth, room for two results of one item plus slack
  localparam int FIFO_DEPTH = 4;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SEP_BYTES   = 2'd0,
    REG_SEP_LEN     = 2'd1,
    REG_DROP_EMPTY  = 2'd2,
    REG_SPLIT_LIMIT = 2'd3
  } cfg_reg_t;

  // one reported piece
  typedef struct packed {
    logic               final_piece;
    logic [PIECE_W-1:0] index;
    logic [PIECE_W-1:0] length;
    logic [PIECE_W-1:0] start;
  } piece_t;

  // up to two pieces pushed by one item, separator piece first
  typedef struct packed {
    logic   first_valid;
    logic   second_valid;
    piece_t first;
    piece_t second;
  } push_t;

endpackage

/* rtl/sss_cell.sv */
// one byte cell of the separator match window
// holds one byte of the recent-byte chain and compares the incoming byte; no dependencies
module sss_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] din,
  input  logic [7:0] want,
  input  logic       used,
  output logic [7:0] q,
  output logic       hit
);

  // byte moves one cell down the chain per consumed byte
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= din;
    end
  end

  // compare against the byte that lands here, cells past the separator always agree
  assign hit = !used || (din == want);

endmodule

/* rtl/sss_fifo.sv */
// result queue of the string separator splitter
// depends on sss_pkg; takes up to two pieces per cycle, hands out one when ready
module sss_fifo (
  input  logic            clk,
  input  logic            rst,
  input  sss_pkg::push_t  push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output sss_pkg::piece_t out_piece,
  output logic [$clog2(sss_pkg::FIFO_DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(sss_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(sss_pkg::FIFO_DEPTH + 1);

  sss_pkg::piece_t mem [sss_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr_second;
  logic [CNT_W-1:0] push_n;
  logic             pop;

  // second piece goes behind the first when both are present
  assign wr_ptr_second = push.first_valid ? wr_ptr + PTR_W'(1) : wr_ptr;
  assign push_n = CNT_W'(push.first_valid) + CNT_W'(push.second_valid);
  assign pop = out_valid && out_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push.first_valid) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.second_valid) begin
      mem[wr_ptr_second] <= push.second;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + push_n - CNT_W'(pop);
    end
  end

  assign out_valid = (count != '0);
  assign out_piece = mem[rd_ptr];
  assign room = (count <= CNT_W'(sss_pkg::FIFO_DEPTH - 2));

endmodule

/* rtl/string_separator_splitter.sv */
// top level of the string separator splitter
// depends on sss_pkg, sss_cell and sss_fifo
//
// Takes a string one byte per item and reports each piece between separator
// matches as (start, length, index), with tlast on the final piece of the
// string. The block consumes one byte per clock: a row of SEP_MAX byte cells
// shifts the recent bytes along and compares all of them against the
// separator in the same cycle. One item gives at most two pieces, which go
// into a four-entry result queue; the input is ready whenever the queue has
// two free entries, so the rate is one item per cycle as long as the output
// side takes pieces at least as fast as they are made. Offsets saturate at
// MAX_LEN and are reported in their low 16 bits. No clearing pass follows reset.
module string_separator_splitter #(
  parameter int                SEP_MAX = 8,
  parameter longint unsigned   MAX_LEN = 65535
) (
  input  logic        clk,
  input  logic        rst,
  // input item
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tuser,   // [0] has_char
  input  logic        s_axis_tlast,   // end_of_string
  // result item
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [15:0] piece_start, [31:16] piece_length,
                                      // [47:32] piece_index
  output logic        m_axis_tlast,   // final_piece
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int LEN_W = $clog2(SEP_MAX + 1);
  localparam int IDX_W = (SEP_MAX > 1) ? $clog2(SEP_MAX) : 1;
  localparam int POS_W = $clog2(MAX_LEN + 64'd1);
  localparam int PW    = sss_pkg::PIECE_W;
  localparam int CNT_W = $clog2(sss_pkg::FIFO_DEPTH + 1);

  // configuration
  logic [7:0]       sep_byte [SEP_MAX];
  logic [LEN_W-1:0] sep_len;
  logic             drop_empty;
  logic [PW-1:0]    split_limit;

  // string state
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] begin_pos;
  logic [PW-1:0]    emitted;
  logic             done;

  logic [POS_W-1:0] pos_next;
  logic [POS_W-1:0] begin_next;
  logic [PW-1:0]    emitted_next;
  logic             done_next;

  logic             accept;
  logic             shift;
  logic [7:0]       cell_q    [SEP_MAX];
  logic [7:0]       cell_din  [SEP_MAX];
  logic [7:0]       cell_want [SEP_MAX];
  logic [SEP_MAX-1:0] cell_used;
  logic [SEP_MAX-1:0] cell_hit;

  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] len_ext;
  logic [POS_W-1:0] match_base;
  logic [POS_W-1:0] sep_plen;
  logic [POS_W-1:0] fin_plen;
  logic             match;
  logic             emit_sep;
  logic             emit_fin;
  logic [PW-1:0]    emitted_mid;
  logic [POS_W-1:0] begin_mid;
  logic             done_mid;

  sss_pkg::push_t   push;
  sss_pkg::piece_t  out_piece;
  logic             room;
  logic [CNT_W-1:0] fifo_count;

  assign cfg_ready = 1'b1;
  assign s_axis_tready = room;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign shift = accept && s_axis_tuser;

  // configuration registers, separator length clamped on write
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < SEP_MAX; j++) begin
        sep_byte[j] <= '0;
      end
      sep_len     <= LEN_W'(1);
      drop_empty  <= 1'b0;
      split_limit <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sss_pkg::cfg_reg_t'(cfg_index))
        sss_pkg::REG_SEP_BYTES: begin
          for (int j = 0; j < SEP_MAX; j++) begin
            sep_byte[j] <= cfg_data[8*j +: 8];
          end
        end
        sss_pkg::REG_SEP_LEN: begin
          if (cfg_data[3:0] == 4'd0) begin
            sep_len <= LEN_W'(1);
          end else if (int'(cfg_data[3:0]) > SEP_MAX) begin
            sep_len <= LEN_W'(SEP_MAX);
          end else begin
            sep_len <= LEN_W'(cfg_data[3:0]);
          end
        end
        sss_pkg::REG_DROP_EMPTY: begin
          drop_empty <= cfg_data[0];
        end
        sss_pkg::REG_SPLIT_LIMIT: begin
          split_limit <= cfg_data[PW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // cell j holds the byte j places back and checks separator byte len-1-j
  always_comb begin
    for (int j = 0; j < SEP_MAX; j++) begin
      cell_used[j] = (LEN_W'(j) < sep_len);
      cell_want[j] = sep_byte[IDX_W'(int'(sep_len) - 1 - j)];
      cell_din[j]  = (j == 0) ? s_axis_tdata : cell_q[(j == 0) ? 0 : j - 1];
    end
  end

  // row of window cells
  for (genvar g = 0; g < SEP_MAX; g++) begin : g_cell
    sss_cell u_cell (
      .clk  (clk),
      .shift(shift),
      .din  (cell_din[g]),
      .want (cell_want[g]),
      .used (cell_used[g]),
      .q    (cell_q[g]),
      .hit  (cell_hit[g])
    );
  end

  // separator match ending at this byte
  always_comb begin
    pos_inc    = (pos < POS_W'(MAX_LEN)) ? pos + POS_W'(1) : pos;
    len_ext    = POS_W'(sep_len);
    match_base = pos_inc - len_ext;
    sep_plen   = match_base - begin_pos;
    match      = s_axis_tuser && !done && (pos_inc >= len_ext) &&
                 (match_base >= begin_pos) && (&cell_hit);
    emit_sep   = match && (!drop_empty || sep_plen != '0);
    emitted_mid = (emit_sep && emitted != '1) ? emitted + PW'(1) : emitted;
    begin_mid  = match ? pos_inc : begin_pos;
    done_mid   = done || (match && split_limit != '0 && emitted_mid == split_limit);
  end

  // end of string piece and next state
  always_comb begin
    pos_next     = s_axis_tuser ? pos_inc : pos;
    fin_plen     = pos_next - begin_mid;
    emit_fin     = s_axis_tlast && (!drop_empty || fin_plen != '0);
    begin_next   = begin_mid;
    emitted_next = emitted_mid;
    done_next    = done_mid;
    if (s_axis_tlast) begin
      pos_next     = '0;
      begin_next   = '0;
      emitted_next = '0;
      done_next    = 1'b0;
    end
  end

  // string state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      begin_pos <= '0;
      emitted   <= '0;
      done      <= 1'b0;
    end else if (accept) begin
      pos       <= pos_next;
      begin_pos <= begin_next;
      emitted   <= emitted_next;
      done      <= done_next;
    end
  end

  // pieces handed to the result queue
  always_comb begin
    push.first_valid         = accept && emit_sep;
    push.second_valid        = accept && emit_fin;
    push.first.final_piece   = 1'b0;
    push.first.index         = emitted;
    push.first.length        = PW'(sep_plen);
    push.first.start         = PW'(begin_pos);
    push.second.final_piece  = 1'b1;
    push.second.index        = emitted_mid;
    push.second.length       = PW'(fin_plen);
    push.second.start        = PW'(begin_mid);
  end

  sss_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_piece(out_piece),
    .count    (fifo_count)
  );

  assign m_axis_tdata = {out_piece.index, out_piece.length, out_piece.start};
  assign m_axis_tlast = out_piece.final_piece;

  // open piece never starts past the consumed bytes
  a_begin_le_pos: assert property (@(posedge clk) disable iff (rst)
    begin_pos <= pos)
    else $error("piece start beyond byte position");

  // an accepted end of string returns the string state to its start
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && s_axis_tlast |=> pos == '0 && begin_pos == '0 && emitted == '0 && !done)
    else $error("string state not cleared after end of string");

  // the result queue never holds more than its depth
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= CNT_W'(sss_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

endmodule

/* verif/string_separator_splitter_tb.sv */
// testbench for string_separator_splitter: directed table, random strings
// and an output hold-off, checked per field against typed or predicted pieces
// depends on sss_pkg and the string_separator_splitter rtl
module string_separator_splitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEP_BYTES_MAX = 8;
  localparam int OFFSET_CEIL   = 65535;
  localparam int RANDOM_ITEMS  = 520;
  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 16;
  localparam int STALL_LIMIT   = 2000;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [7:0]         ch;
    logic               has;
    logic               eos;
    sss_pkg::cfg_reg_t  reg_idx;
    logic [63:0]        reg_val;
    bit                 typed;
    int                 n_want;
    sss_pkg::piece_t    want0;
    sss_pkg::piece_t    want1;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] char_in
  logic        s_axis_tuser = 1'b0; // [0] has_char
  logic        s_axis_tlast = 1'b0; // end_of_string
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // [15:0] piece_start, [31:16] piece_length,
                                    // [47:32] piece_index
  logic        m_axis_tlast;        // final_piece
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  sss_pkg::cfg_reg_t cfg_index = sss_pkg::REG_SEP_BYTES;
  logic [63:0] cfg_data = '0;

  // register copies, at their reset values
  logic [63:0] sep_word = '0;
  logic [3:0]  sep_len_cfg = 4'd1;
  logic        drop_empty_cfg = 1'b0;
  logic [15:0] split_limit_cfg = '0;

  // splitter state copy
  logic [7:0]  window_q [SEP_BYTES_MAX] = '{default: 8'h00};
  int          byte_pos = 0;
  int          open_start = 0;
  int          pieces_out = 0;
  bit          limit_hit = 1'b0;

  sss_pkg::piece_t expected_pieces[$];
  sss_pkg::piece_t fresh_pieces[$];
  sss_pkg::piece_t typed_want[$];
  bit          typed_on = 1'b0;
  int          fail_count = 0;
  int          in_idle_pct = 36;
  int          out_idle_pct = 36;
  bit          hold_request = 1'b0;
  int          quiet_cycles = 0;

  string_separator_splitter dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic sss_pkg::piece_t make_piece(int start, int len, int idx, bit fin);
    sss_pkg::piece_t p;
    p.start       = 16'(start);
    p.length      = 16'(len);
    p.index       = 16'(idx);
    p.final_piece = fin;
    return p;
  endfunction

  // pieces caused by one input item, appended to fresh_pieces
  function automatic void predict_pieces(logic [7:0] ch, logic has, logic eos);
    int  used_len;
    int  plen;
    int  k;
    bit  hit;
    used_len = (sep_len_cfg == 0) ? 1 :
               (sep_len_cfg > SEP_BYTES_MAX) ? SEP_BYTES_MAX : int'(sep_len_cfg);
    if (has) begin
      for (k = SEP_BYTES_MAX - 1; k > 0; k--) window_q[k] = window_q[k-1];
      window_q[0] = ch;
      if (byte_pos < OFFSET_CEIL) byte_pos++;
      // newest byte closes the separator when the window reads it in order
      hit = 1'b1;
      for (k = 0; k < used_len; k++)
        if (window_q[used_len-1-k] != sep_word[8*k +: 8]) hit = 1'b0;
      if (!limit_hit && byte_pos >= used_len && byte_pos - used_len >= open_start && hit)
      begin
        plen = byte_pos - used_len - open_start;
        if (!drop_empty_cfg || plen != 0) begin
          fresh_pieces.push_back(make_piece(open_start, plen, pieces_out, 1'b0));
          if (pieces_out < 16'hFFFF) pieces_out++;
        end
        open_start = byte_pos;
        if (split_limit_cfg != 0 && pieces_out == split_limit_cfg) limit_hit = 1'b1;
      end
    end
    if (eos) begin
      plen = byte_pos - open_start;
      if (!drop_empty_cfg || plen != 0)
        fresh_pieces.push_back(make_piece(open_start, plen, pieces_out, 1'b1));
      window_q   = '{default: 8'h00};
      byte_pos   = 0;
      open_start = 0;
      pieces_out = 0;
      limit_hit  = 1'b0;
    end
  endfunction

  // predict on accepted items, check accepted pieces, track register writes
  always @(posedge clk) begin : monitor
    sss_pkg::piece_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pieces.size() == 0) begin
          $error("piece with nothing expected: start %0d length %0d index %0d last %0b",
                 m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32], m_axis_tlast);
          fail_count++;
        end else begin
          want = expected_pieces.pop_front();
          if (m_axis_tdata[15:0] !== want.start) begin
            $error("piece_start expected %0d actual %0d", want.start, m_axis_tdata[15:0]);
            fail_count++;
          end
          if (m_axis_tdata[31:16] !== want.length) begin
            $error("piece_length expected %0d actual %0d", want.length, m_axis_tdata[31:16]);
            fail_count++;
          end
          if (m_axis_tdata[47:32] !== want.index) begin
            $error("piece_index expected %0d actual %0d", want.index, m_axis_tdata[47:32]);
            fail_count++;
          end
          if (m_axis_tlast !== want.final_piece) begin
            $error("final_piece expected %0b actual %0b", want.final_piece, m_axis_tlast);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_pieces(s_axis_tdata, s_axis_tuser, s_axis_tlast);
        if (typed_on) begin
          foreach (typed_want[j]) expected_pieces.push_back(typed_want[j]);
        end else begin
          foreach (fresh_pieces[j]) expected_pieces.push_back(fresh_pieces[j]);
        end
        fresh_pieces.delete();
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sss_pkg::REG_SEP_BYTES:   sep_word = cfg_data;
          sss_pkg::REG_SEP_LEN:     sep_len_cfg = cfg_data[3:0];
          sss_pkg::REG_DROP_EMPTY:  drop_empty_cfg = cfg_data[0];
          sss_pkg::REG_SPLIT_LIMIT: split_limit_cfg = cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $error("no handshake for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      m_axis_tready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // offer one item; called and returns at a falling edge, tvalid left high
  task automatic send_item(logic [7:0] ch, logic has, logic eos);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= has;
    s_axis_tlast  <= eos;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // all pieces in, then let the pipeline empty out
  task automatic wait_idle();
    while (expected_pieces.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // one register write; cfg_valid left high for the caller to drop
  task automatic write_reg(sss_pkg::cfg_reg_t idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic configure(logic [63:0] bytes, logic [3:0] len, logic drop, logic [15:0] lim);
    s_axis_tvalid <= 1'b0;
    wait_idle();
    write_reg(sss_pkg::REG_SEP_BYTES, bytes);
    write_reg(sss_pkg::REG_SEP_LEN, 64'(len));
    write_reg(sss_pkg::REG_DROP_EMPTY, 64'(drop));
    write_reg(sss_pkg::REG_SPLIT_LIMIT, 64'(lim));
    cfg_valid <= 1'b0;
  endtask

  function automatic dir_row_t item_row(logic [7:0] ch, logic has, logic eos,
                                        int n_typed = -1,
                                        sss_pkg::piece_t w0 = '0,
                                        sss_pkg::piece_t w1 = '0);
    dir_row_t r;
    r.kind    = ROW_ITEM;
    r.ch      = ch;
    r.has     = has;
    r.eos     = eos;
    r.reg_idx = sss_pkg::REG_SEP_BYTES;
    r.reg_val = '0;
    r.typed   = (n_typed >= 0);
    r.n_want  = n_typed;
    r.want0   = w0;
    r.want1   = w1;
    return r;
  endfunction

  function automatic dir_row_t reg_row(sss_pkg::cfg_reg_t idx, logic [63:0] val);
    dir_row_t r;
    r         = item_row(8'h00, 1'b0, 1'b0);
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // stimulus
  initial begin : driver
    dir_row_t    dir_rows[$];
    logic [7:0]  text[$];
    logic [63:0] cur_bytes;
    logic [3:0]  cur_len;
    logic [15:0] lim;
    int          eff_len;
    int          str_len;
    int          pick;
    int          prefix;
    int          k;
    int          string_no;
    int          items_sent;
    bit          tail_on_byte;
    bit          quiet;

    // directed table; reset separator is one zero byte
    dir_rows.push_back(item_row(8'hFF, 1'b0, 1'b1, 1, make_piece(0, 0, 0, 1'b1)));
    dir_rows.push_back(item_row(8'h00, 1'b0, 1'b0, 0));
    dir_rows.push_back(item_row(8'h00, 1'b1, 1'b1, 2, make_piece(0, 0, 0, 1'b0),
                                make_piece(1, 0, 1, 1'b1)));
    dir_rows.push_back(item_row(8'hFF, 1'b1, 1'b1, 1, make_piece(0, 1, 0, 1'b1)));
    // length zero behaves as one
    dir_rows.push_back(reg_row(sss_pkg::REG_SEP_LEN, 64'd0));
    dir_rows.push_back(item_row(8'h00, 1'b1, 1'b0));
    dir_rows.push_back(item_row(8'h00, 1'b1, 1'b1));
    // all-ones separator, length above the maximum behaves as eight
    dir_rows.push_back(reg_row(sss_pkg::REG_SEP_BYTES, 64'hFFFF_FFFF_FFFF_FFFF));
    dir_rows.push_back(reg_row(sss_pkg::REG_SEP_LEN, 64'd15));
    for (k = 0; k < 8; k++) dir_rows.push_back(item_row(8'hFF, 1'b1, k == 7));
    // two-byte separator, empty pieces dropped, split after one piece
    dir_rows.push_back(reg_row(sss_pkg::REG_SEP_BYTES, 64'h0201));
    dir_rows.push_back(reg_row(sss_pkg::REG_SEP_LEN, 64'd2));
    dir_rows.push_back(reg_row(sss_pkg::REG_DROP_EMPTY, 64'd1));
    dir_rows.push_back(reg_row(sss_pkg::REG_SPLIT_LIMIT, 64'd1));
    dir_rows.push_back(item_row(8'h01, 1'b1, 1'b0));
    dir_rows.push_back(item_row(8'h02, 1'b1, 1'b0));
    dir_rows.push_back(item_row(8'h05, 1'b1, 1'b0));
    dir_rows.push_back(item_row(8'h01, 1'b1, 1'b0));
    dir_rows.push_back(item_row(8'h02, 1'b1, 1'b0));
    dir_rows.push_back(item_row(8'h06, 1'b1, 1'b1));
    // largest split limit, end marker with no byte after a string
    dir_rows.push_back(reg_row(sss_pkg::REG_SPLIT_LIMIT, 64'hFFFF));
    dir_rows.push_back(reg_row(sss_pkg::REG_DROP_EMPTY, 64'd0));
    dir_rows.push_back(reg_row(sss_pkg::REG_SEP_BYTES, 64'h41));
    dir_rows.push_back(reg_row(sss_pkg::REG_SEP_LEN, 64'd1));
    dir_rows.push_back(item_row(8'h41, 1'b1, 1'b0));
    dir_rows.push_back(item_row(8'h80, 1'b1, 1'b0));
    dir_rows.push_back(item_row(8'h7F, 1'b0, 1'b1));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        s_axis_tvalid <= 1'b0;
        wait_idle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
        cfg_valid <= 1'b0;
      end else begin
        typed_on = dir_rows[i].typed;
        typed_want.delete();
        if (dir_rows[i].n_want > 0) typed_want.push_back(dir_rows[i].want0);
        if (dir_rows[i].n_want > 1) typed_want.push_back(dir_rows[i].want1);
        send_item(dir_rows[i].ch, dir_rows[i].has, dir_rows[i].eos);
      end
    end
    typed_on = 1'b0;

    // output hold-off while separators keep coming
    configure(64'h2C, 4'd1, 1'b0, 16'd0);
    in_idle_pct  = 0;
    hold_request = 1'b1;
    for (k = 0; k < 40; k++) send_item((k % 3 == 2) ? 8'h61 : 8'h2C, 1'b1, k == 39);

    // random strings built from separator pieces, near misses and noise
    items_sent = 0;
    string_no  = 0;
    cur_bytes  = '0;
    eff_len    = 1;
    while (items_sent < RANDOM_ITEMS) begin
      if (string_no % 3 == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) cur_len = 4'($urandom_range(1, 3));
        else if (pick < 85) cur_len = 4'($urandom_range(4, 8));
        else begin
          cur_len = 4'($urandom_range(0, 7));
          if (cur_len != 0) cur_len = cur_len + 4'd8;
        end
        eff_len = (cur_len == 0) ? 1 : (cur_len > SEP_BYTES_MAX) ? SEP_BYTES_MAX : cur_len;
        if ($urandom_range(0, 9) == 0) begin
          cur_bytes = {$urandom, $urandom};
        end else begin
          for (k = 0; k < 8; k++) begin
            case ($urandom_range(0, 4))
              0: cur_bytes[8*k +: 8] = 8'h2C;
              1: cur_bytes[8*k +: 8] = 8'h3B;
              2: cur_bytes[8*k +: 8] = 8'h00;
              3: cur_bytes[8*k +: 8] = 8'hFF;
              default: cur_bytes[8*k +: 8] = 8'($urandom);
            endcase
          end
        end
        pick = $urandom_range(0, 99);
        if (pick < 50) lim = 16'd0;
        else if (pick < 85) lim = 16'($urandom_range(1, 3));
        else if (pick < 95) lim = 16'($urandom_range(4, 65535));
        else lim = 16'hFFFF;
        configure(cur_bytes, cur_len, 1'($urandom_range(0, 1)), lim);
      end

      // a run of strings with no idling on either side
      quiet        = (string_no >= 12 && string_no < 30);
      in_idle_pct  = quiet ? 0 : 36;
      out_idle_pct = quiet ? 0 : 36;

      str_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
      text.delete();
      while (text.size() < str_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          for (k = 0; k < eff_len; k++) text.push_back(cur_bytes[8*k +: 8]);
        end else if (pick < 40) begin
          prefix = $urandom_range(1, eff_len);
          for (k = 0; k < prefix; k++) text.push_back(cur_bytes[8*k +: 8]);
        end else if (pick < 60) begin
          text.push_back(cur_bytes[8*$urandom_range(0, eff_len - 1) +: 8]);
        end else if (pick < 70) begin
          text.push_back(8'h61);
        end else begin
          text.push_back(8'($urandom));
        end
      end

      tail_on_byte = $urandom_range(0, 1);
      foreach (text[i]) begin
        if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
        send_item(text[i], 1'b1, tail_on_byte && (i == text.size() - 1));
        items_sent++;
      end
      if (!tail_on_byte || text.size() == 0) begin
        send_item(8'($urandom), 1'b0, 1'b1);
        items_sent++;
      end
      string_no++;
    end

    s_axis_tvalid <= 1'b0;
    while (expected_pieces.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
